// ===== rtl/mtdf_pkg.sv =====
package mtdf_pkg;

    // input item kinds (kind 3 decodes as a clear)
    localparam logic [1:0] KIND_FILTER = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;

    localparam logic [3:0] ST_PASS_NONE = 4'd0;
    localparam logic [3:0] ST_PASS_DIV  = 4'd1;
    localparam logic [3:0] ST_SHORT     = 4'd2;
    localparam logic [3:0] ST_ZERO_DIV  = 4'd3;
    localparam logic [3:0] ST_DECIMATED = 4'd4;
    localparam logic [3:0] ST_NO_RULE   = 4'd5;
    localparam logic [3:0] ST_STORED    = 4'd6;
    localparam logic [3:0] ST_FULL      = 4'd7;
    localparam logic [3:0] ST_CLEARED   = 4'd8;

    typedef enum logic [1:0] {
        OP_FILTER,
        OP_APPEND,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        short_msg;
        logic [15:0] type_id;
        logic [15:0] divisor;
    } cmd_t;

    typedef struct packed {
        logic [15:0] rtype;
        logic [15:0] div;
        logic [15:0] cnt;
    } row_t;

    typedef struct packed {
        logic       pass_msg;
        logic [3:0] status;
    } res_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } bk_state_t;

endpackage

// ===== rtl/mtdf_ram.sv =====
module mtdf_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/mtdf_fifo.sv =====
// two-entry queue, full and empty straight from the fill count
module mtdf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/mtdf_front.sv =====
// decodes the item kind, flags short messages, queues the command
module mtdf_front import mtdf_pkg::*; #(
    parameter int MIN_MSG_LENGTH = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] type_id,
    input  logic [9:0]  frame_len,
    input  logic [15:0] rule_divisor,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    localparam logic [9:0] MIN_LEN = 10'(MIN_MSG_LENGTH);

    cmd_t in_cmd;
    logic cmd_empty;

    always_comb
    begin
        case (kind)
            KIND_FILTER: in_cmd.op = OP_FILTER;
            KIND_APPEND: in_cmd.op = OP_APPEND;
            default:     in_cmd.op = OP_CLEAR;
        endcase
        in_cmd.short_msg = (frame_len < MIN_LEN);
        in_cmd.type_id   = type_id;
        in_cmd.divisor   = rule_divisor;
    end

    mtdf_fifo #(
        .WIDTH($bits(cmd_t))
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_cmd),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

// ===== rtl/mtdf_back.sv =====
// executes commands against the rule table; a filter walks the rules one a cycle
module mtdf_back import mtdf_pkg::*; #(
    parameter int MAX_RULES = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic res_push,
    output res_t res_data,
    input  logic res_full
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RULES);

    bk_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    row_t              wr_row;
    logic [IDX_W-1:0]  rd_addr;
    row_t              rd_row;
    logic [3:0]        res_status;

    logic              rd_more;
    logic              hit;
    logic [15:0]       cnt_inc;
    logic              start_ok;
    logic              start_scan;

    mtdf_ram #(
        .WIDTH($bits(row_t)),
        .DEPTH(MAX_RULES)
    ) u_rule_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    // rd_row holds the rule at chk_idx_reg when chk_valid_reg is set
    assign rd_more    = (idx_reg != count_reg);
    assign hit        = chk_valid_reg && (rd_row.rtype == cmd.type_id);
    assign cnt_inc    = rd_row.cnt + 16'd1;
    assign start_ok   = cmd_valid && !res_full;
    assign start_scan = start_ok && (cmd.op == OP_FILTER) && (count_reg != '0)
                        && !cmd.short_msg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (hit || !rd_more)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_row         = rd_row;
        rd_addr        = idx_reg[IDX_W-1:0];
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_status     = ST_NO_RULE;
        case (state_reg)
            BK_IDLE:
            begin
                idx_next       = '0;
                chk_valid_next = 1'b0;
                if (start_ok)
                begin
                    case (cmd.op)
                        OP_FILTER:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = ST_PASS_NONE;
                                res_push   = 1'b1;
                                cmd_pop    = 1'b1;
                            end
                            else if (cmd.short_msg)
                            begin
                                res_status = ST_SHORT;
                                res_push   = 1'b1;
                                cmd_pop    = 1'b1;
                            end
                        end
                        OP_APPEND:
                        begin
                            res_push = 1'b1;
                            cmd_pop  = 1'b1;
                            if (count_reg == MAX_CNT)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_row     = '{rtype: cmd.type_id, div: cmd.divisor, cnt: 16'd0};
                                count_next = count_reg + 1'b1;
                                res_status = ST_STORED;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                            res_status = ST_CLEARED;
                            res_push   = 1'b1;
                            cmd_pop    = 1'b1;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                chk_valid_next = rd_more;
                chk_idx_next   = idx_reg[IDX_W-1:0];
                if (rd_more)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (hit)
                begin
                    res_push = 1'b1;
                    cmd_pop  = 1'b1;
                    if (rd_row.div == 16'd0)
                    begin
                        res_status = ST_ZERO_DIV;
                    end
                    else if (cnt_inc >= rd_row.div)
                    begin
                        wr_en      = 1'b1;
                        wr_row.cnt = 16'd0;
                        res_status = ST_PASS_DIV;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_row.cnt = cnt_inc;
                        res_status = ST_DECIMATED;
                    end
                end
                else if (!rd_more)
                begin
                    res_status = ST_NO_RULE;
                    res_push   = 1'b1;
                    cmd_pop    = 1'b1;
                end
            end
            default:
            begin
                chk_valid_next = 1'b0;
            end
        endcase
    end

    assign res_data = '{pass_msg: (res_status == ST_PASS_NONE) || (res_status == ST_PASS_DIV),
                        status: res_status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("rule count beyond table size");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_push == cmd_pop)
        else $error("command retired without exactly one result");

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into full queue");

    a_scan_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_SCAN |-> cmd_valid && cmd.op == OP_FILTER)
        else $error("scan without a filter command at queue head");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("scan index past rule count");

endmodule

// ===== rtl/message_type_decimation_filter_top.sv =====
// channel  | handshake        | beat fields
// ---------+------------------+-------------------------------------------
// input    | push / full      | kind, type_id, frame_len, rule_divisor
// result   | pop / empty      | pass_msg, status
//
// Every input beat yields exactly one result beat, in order.
// Append, clear, short message or empty table: retired by the executor from idle, with no scan.
// Filter against the table: rules are read one per cycle from the rule RAM
// (one read port, one write port); the scan stops at the first matching rule,
// or after the last rule when none matches.
// Reset: asynchronous, clears the rule count; the rule RAM is not cleared.
// Both sides stall independently; two-entry queues sit on each side.
module message_type_decimation_filter_top import mtdf_pkg::*; #(
    parameter int MAX_RULES      = 256,
    parameter int MIN_MSG_LENGTH = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] type_id,
    input  logic [9:0]  frame_len,
    input  logic [15:0] rule_divisor,
    output logic        empty,
    input  logic        pop,
    output logic        pass_msg,
    output logic [3:0]  status
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    logic res_push;
    res_t res_in;
    res_t res_out;
    logic res_full;

    mtdf_front #(
        .MIN_MSG_LENGTH(MIN_MSG_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .type_id      (type_id),
        .frame_len    (frame_len),
        .rule_divisor (rule_divisor),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    mtdf_back #(
        .MAX_RULES(MAX_RULES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_data  (res_in),
        .res_full  (res_full)
    );

    mtdf_fifo #(
        .WIDTH($bits(res_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign pass_msg = res_out.pass_msg;
    assign status   = res_out.status;

endmodule
